/* sv/rlsf_pkg.sv */
// ----------------------------------------------------------------------------
// rlsf_pkg
// Shared types, constants and the color wheel function for the LED strip
// framer.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  localparam int unsigned LedCount = 3;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_RAINBOW = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [4:0] BrightReset = 5'd1;
  localparam logic [7:0] HeaderMark  = 8'hE0;
  localparam logic [7:0] StartByte   = 8'h00;
  localparam logic [7:0] EndByte     = 8'hFF;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] led_sel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic frame;
    logic error;
  } emit_req_t;

  // Returns {red, green, blue}.
  function automatic logic [23:0] wheel_color(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] p3;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    p = 8'd255 - pos;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    p3 = 8'({q, 1'b0} + {1'b0, q});
    if (p < 8'd85) begin
      r = 8'd255 - p3;
      g = 8'd0;
      b = p3;
    end else if (p < 8'd170) begin
      r = 8'd0;
      g = p3;
      b = 8'd255 - p3;
    end else begin
      r = p3;
      g = 8'd255 - p3;
      b = 8'd0;
    end
    return {r, g, b};
  endfunction

endpackage

/* sv/rlsf_emitter.sv */
// ----------------------------------------------------------------------------
// rlsf_emitter
// Frame byte sequencer: walks start bytes, per-LED header and color bytes and
// end bytes, one beat per cycle into an output register unless the receiver
// stalls; also sends the invalid index report.
// ----------------------------------------------------------------------------
module rlsf_emitter import rlsf_pkg::*; #(
  parameter int unsigned LED_COUNT = LedCount,
  localparam int unsigned LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  emit_req_t       req_i,
  input  logic [4:0]      brightness_i,
  input  logic [23:0]     led_color_i,
  output logic [LedW-1:0] led_idx_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_beat_t       out_beat_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_HEAD,
    E_LEDS,
    E_TAIL,
    E_ERR
  } emit_state_e;

  localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);

  emit_state_e     state_q, state_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [LedW-1:0] led_q, led_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_beat_q, out_beat_d;
  logic            slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign busy_o      = (state_q != E_IDLE);
  assign led_idx_o   = led_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    led_d       = led_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_beat_d  = out_beat_q;
    case (state_q)
      E_IDLE: begin
        cnt_d = 2'd0;
        led_d = '0;
        if (req_i.error) begin
          state_d = E_ERR;
        end else if (req_i.frame) begin
          state_d = E_HEAD;
        end
      end
      E_HEAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_beat_d  = '{kind: KIND_FRAME, frame_byte: StartByte, last: 1'b0};
          cnt_d       = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_d = E_LEDS;
          end
        end
      end
      E_LEDS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_beat_d.kind = KIND_FRAME;
          out_beat_d.last = 1'b0;
          case (cnt_q)
            2'd0:    out_beat_d.frame_byte = HeaderMark | {3'd0, brightness_i};
            2'd1:    out_beat_d.frame_byte = led_color_i[7:0];
            2'd2:    out_beat_d.frame_byte = led_color_i[15:8];
            default: out_beat_d.frame_byte = led_color_i[23:16];
          endcase
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (led_q == LastLed) begin
              state_d = E_TAIL;
            end else begin
              led_d = led_q + LedW'(1);
            end
          end
        end
      end
      E_TAIL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_beat_d  = '{kind: KIND_FRAME, frame_byte: EndByte, last: (cnt_q == 2'd3)};
          cnt_d       = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_d = E_IDLE;
          end
        end
      end
      E_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_beat_d  = '{kind: KIND_ERROR, frame_byte: 8'd0, last: 1'b1};
          state_d     = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      cnt_q       <= 2'd0;
      led_q       <= '0;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
      out_beat_q  <= out_beat_d;
    end
  end

endmodule

/* sv/rainbow_led_strip_framer_unit.sv */
// ----------------------------------------------------------------------------
// rainbow_led_strip_framer_unit
// LED strip framer with per-LED colors and a color wheel rainbow mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) takes commands: tick,
//   set one LED color and clear all others, start rainbow mode. Output
//   channel (out_valid_o / out_stall_i / out_beat_o) gives frame bytes or an
//   invalid index report, with last set on the final beat of each one.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the 5-bit
//   brightness; always ready, write only while idle.
//   Set and rainbow commands give no beats; an invalid index sends the
//   sequencer to its error state, which loads the report beat.
//   A tick in pending mode streams 8 + 4*LED_COUNT bytes, one per cycle while
//   the receiver does not stall, the first loaded into the output register
//   after the sequencer leaves idle; the next command is taken when it is
//   idle again. A tick in rainbow mode first writes the wheel color into
//   each LED. in_stall_o stays high until the last beat is in the output
//   register. A receiver stall holds the output register and pauses the
//   sequencer. Reset clears all LED colors, the wheel position and the mode;
//   brightness returns to 1.
// ----------------------------------------------------------------------------
module rainbow_led_strip_framer_unit import rlsf_pkg::*; #(
  parameter int unsigned LED_COUNT = LedCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RAINBOW,
    MODE_PENDING
  } mode_e;

  typedef enum logic {
    T_IDLE,
    T_FILL
  } top_state_e;

  top_state_e      state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [7:0]      wheel_q, wheel_d;
  logic [LedW-1:0] fill_q, fill_d;
  logic [4:0]      bright_q;
  logic [23:0]     colors_q [LED_COUNT];
  logic [23:0]     colors_d [LED_COUNT];
  emit_req_t       req;
  logic            emit_busy;
  logic [LedW-1:0] led_idx;
  logic            in_accept;
  logic            idx_ok;

  assign in_stall_o  = (state_q != T_IDLE) || emit_busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign idx_ok      = ({1'b0, in_beat_i.led_sel} < 5'(LED_COUNT));

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    wheel_d  = wheel_q;
    fill_d   = fill_q;
    colors_d = colors_q;
    req      = '0;
    case (state_q)
      T_IDLE: begin
        fill_d = '0;
        if (in_accept) begin
          case (in_beat_i.command)
            CMD_SET: begin
              for (int i = 0; i < LED_COUNT; i++) begin
                colors_d[i] = 24'd0;
              end
              if (idx_ok) begin
                colors_d[in_beat_i.led_sel[LedW-1:0]] =
                  {in_beat_i.red, in_beat_i.green, in_beat_i.blue};
                mode_d = MODE_PENDING;
              end else begin
                req.error = 1'b1;
              end
            end
            CMD_RAINBOW: mode_d = MODE_RAINBOW;
            CMD_TICK: begin
              if (mode_q == MODE_PENDING) begin
                mode_d    = MODE_IDLE;
                req.frame = 1'b1;
              end else if (mode_q == MODE_RAINBOW) begin
                state_d = T_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      T_FILL: begin
        colors_d[fill_q] = wheel_color(wheel_q);
        fill_d           = fill_q + LedW'(1);
        if (fill_q == LastLed) begin
          req.frame = 1'b1;
          wheel_d   = wheel_q + 8'd1;
          state_d   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      mode_q   <= MODE_IDLE;
      wheel_q  <= 8'd0;
      fill_q   <= '0;
      bright_q <= BrightReset;
      for (int i = 0; i < LED_COUNT; i++) begin
        colors_q[i] <= 24'd0;
      end
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      wheel_q  <= wheel_d;
      fill_q   <= fill_d;
      colors_q <= colors_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bright_q <= cfg_data_i;
      end
    end
  end

  rlsf_emitter #(
    .LED_COUNT(LED_COUNT)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .brightness_i(bright_q),
    .led_color_i (colors_q[led_idx]),
    .led_idx_o   (led_idx),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
